// ===== rtl/core/lfc_pkg.sv =====
// Shared types and constants for the line framer with CRC-16.
// Used by lfc_line_step, lfc_byte_serializer and line_framer_crc16_core.
package lfc_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;
    localparam logic [3:0]  SYNC_NIBBLE = 4'hA;

    localparam logic [2:0]  COUNT_MIDDLE = 3'd2;
    localparam logic [2:0]  COUNT_FIRST  = 3'd3;
    localparam logic [2:0]  COUNT_LAST   = 3'd4;

    // The bytes caused by one payload word; bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            eol;
    } run_t;

    // Eight CRC steps, MSB first.
    function automatic logic [15:0] crc_feed8(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            if (data[i] ^ crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // Four CRC steps, MSB first.
    function automatic logic [15:0] crc_feed4(input logic [15:0] crc_in,
                                              input logic [3:0]  data);
        logic [15:0] crc;
        crc = crc_in;
        for (int i = 3; i >= 0; i--) begin
            if (data[i] ^ crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/lfc_line_step.sv =====
// Line state (running CRC and word position) and the byte run of one word.
// Depends on lfc_pkg.
module lfc_line_step
    import lfc_pkg::*;
#(
    parameter int LINE_WORDS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [15:0] payload_word,
    input  logic [3:0]  header_nibble,
    output run_t        run
);

    localparam int POS_W = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_WORDS - 1);

    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      crc_start;
    logic [15:0]      crc_word;
    logic             first_word;
    logic             last_word;

    assign first_word = (pos_reg == '0);
    assign last_word  = (pos_reg == POS_LAST);

    always_comb
    begin
        crc_start = first_word ? crc_feed4(CRC_INIT, header_nibble) : crc_reg;
        crc_word  = crc_feed8(crc_feed8(crc_start, payload_word[15:8]), payload_word[7:0]);

        run = '0;
        if (first_word) begin
            run.bytes[0] = {SYNC_NIBBLE, header_nibble};
            run.bytes[1] = payload_word[15:8];
            run.bytes[2] = payload_word[7:0];
            run.count    = COUNT_FIRST;
        end
        else if (last_word) begin
            run.bytes[0] = payload_word[15:8];
            run.bytes[1] = payload_word[7:0];
            run.bytes[2] = crc_word[15:8];
            run.bytes[3] = crc_word[7:0];
            run.count    = COUNT_LAST;
            run.eol      = 1'b1;
        end
        else begin
            run.bytes[0] = payload_word[15:8];
            run.bytes[1] = payload_word[7:0];
            run.count    = COUNT_MIDDLE;
        end

        if (last_word) begin
            crc_next = CRC_INIT;
            pos_next = '0;
        end
        else begin
            crc_next = crc_word;
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg <= CRC_INIT;
            pos_reg <= '0;
        end
        else if (accept) begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
        end
    end

    // The position never runs past the end of a line.
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= POS_LAST)
        else $error("word position out of range");
    // Closing a line clears the CRC for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_word |=> crc_reg == CRC_INIT && pos_reg == '0)
        else $error("line state not cleared after last word");
    // The CRC is zero whenever a line is about to start.
    assert property (@(posedge clk) disable iff (!rst_n)
        first_word |-> crc_reg == CRC_INIT)
        else $error("stale CRC at start of line");

endmodule

// ===== rtl/core/lfc_byte_serializer.sv =====
// Holds one word's byte run and sends it out one byte per cycle while out_stall is low.
// Depends on lfc_pkg.
module lfc_byte_serializer
    import lfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  run_t       run_in,
    output logic       busy_hold,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] line_byte,
    output logic       last_in_run,
    output logic       end_of_line
);

    run_t       run_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       last;
    logic       fire;

    assign last        = ({1'b0, idx_reg} == (run_reg.count - 3'd1));
    assign fire        = valid_reg && !out_stall;
    assign out_valid   = valid_reg;
    assign line_byte   = run_reg.bytes[idx_reg];
    assign last_in_run = last;
    assign end_of_line = run_reg.eol && last;
    // A new run may enter once the final byte of the current one leaves.
    assign busy_hold   = valid_reg && !(fire && last);

    always_ff @(posedge clk)
    begin
        if (load) begin
            run_reg <= run_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (fire) begin
            if (last) begin
                valid_reg <= 1'b0;
            end
            else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> run_reg.count >= COUNT_MIDDLE && run_reg.count <= COUNT_LAST)
        else $error("byte run length out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> {1'b0, idx_reg} < run_reg.count)
        else $error("byte index past end of run");
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_hold)
        else $error("run overwritten before its last byte left");
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last && !load |=> valid_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("byte index did not advance");

endmodule

// ===== rtl/core/line_framer_crc16_core.sv =====
// Top level of the line framer: payload words in, framed line bytes out.
// Depends on lfc_pkg, lfc_line_step and lfc_byte_serializer.
//
// Usage:
// The input channel (in_valid, in_stall, payload_word, header_nibble) takes one
// 16-bit payload word per transaction. header_nibble is read only on the first
// word of a line. The output channel (out_valid, out_stall, line_byte,
// last_in_run, end_of_line) carries one byte of the line per transaction, MSB
// first: the header byte 0xA0 | header before the first word, the word's high
// and low bytes, and the CRC-16 high and low bytes after the last word.
// last_in_run marks the final byte caused by a word; end_of_line marks the CRC
// low byte that closes a line.
// Latency: the first byte of a word is offered the cycle after it is accepted.
// Throughput: a word yields 2 bytes, 3 on the first word of a line and 4 on
// the last; the output port moves one byte per cycle while out_stall is low.
// The next word is accepted in the same cycle the previous word's final byte
// is taken, so the output runs without gaps.
// Reset clears the running CRC and the word position and empties the byte
// buffer. While the receiver stalls, the current byte holds and in_stall
// rises once the buffered word's bytes are not yet all delivered.
module line_framer_crc16_core
    import lfc_pkg::*;
#(
    parameter int WORDS_PER_LINE = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] payload_word,
    input  logic [3:0]  header_nibble,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  line_byte,
    output logic        last_in_run,
    output logic        end_of_line
);

    // A one-word line would need five bytes from one word; lines have at least two.
    localparam int LINE_WORDS = (WORDS_PER_LINE < 2) ? 2 : WORDS_PER_LINE;

    logic in_accept;
    logic busy_hold;
    run_t run;

    assign in_stall  = busy_hold;
    assign in_accept = in_valid && !busy_hold;

    lfc_line_step #(
        .LINE_WORDS (LINE_WORDS)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .payload_word  (payload_word),
        .header_nibble (header_nibble),
        .run           (run)
    );

    lfc_byte_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_accept),
        .run_in      (run),
        .busy_hold   (busy_hold),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_byte   (line_byte),
        .last_in_run (last_in_run),
        .end_of_line (end_of_line)
    );

    // An accepted word always has bytes on offer in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> out_valid)
        else $error("accepted word produced no output");
    // A line end is always the final byte of its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_line |-> last_in_run)
        else $error("end of line on a byte that is not last in its run");
    // The input is held off only while bytes are still waiting.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule
